>>> hw/rtl/sphilox_pkg.sv
// Shared types, constants and helper functions for the seeded Philox generator.
package sphilox_pkg;

  // Philox round count default
  localparam int DEF_ROUNDS = 10;

  // splitmix64 constants
  localparam logic [63:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

  // Philox-4x32 constants
  localparam logic [31:0] PH_MUL_A  = 32'hD251_1F53;
  localparam logic [31:0] PH_MUL_B  = 32'hCD9E_8D57;
  localparam logic [31:0] PH_BUMP_A = 32'h9E37_79B9;
  localparam logic [31:0] PH_BUMP_B = 32'hBB67_AE85;

  // Domain separation words
  localparam logic [63:0] DOMAIN_EPOCH = 64'h4553_5F45_504F_4348;
  localparam logic [63:0] DOMAIN_PAIR  = 64'h4553_5F50_4149_525F;

  // Latency of the mix pipeline in cycles
  localparam int MIX_LAT = 5;
  localparam int KCNT_W  = $clog2(MIX_LAT + 1);

  // Register bus
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int EPOCH_W = 63;

  typedef enum logic [1:0] {
    REG_KEY_HIGH   = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_EPOCH      = 2'd2,
    REG_ANTITHETIC = 2'd3
  } reg_idx_t;

  // Key schedule sequencer: one pass of the mix pipeline per phase
  typedef enum logic [1:0] {
    KS_LOW,
    KS_HIGH,
    KS_EPOCH,
    KS_DONE
  } ks_state_t;

  typedef logic [3:0][31:0] word4_t;

  // Item sideband while the seed is being mixed
  typedef struct packed {
    logic [63:0] counter;
    logic        negate;
    logic        bad;
  } side_t;

  // Item state through the Philox rounds
  typedef struct packed {
    word4_t      w;
    logic [63:0] seed;
    logic        negate;
    logic        bad;
  } ph_t;

  // Round key offset: r times the bump constant, mod 2^32
  function automatic logic [31:0] bump(int unsigned r, logic [31:0] step);
    logic [63:0] t;
    t = 64'(r) * {32'd0, step};
    return t[31:0];
  endfunction

  // One Philox-4x32 round
  function automatic word4_t ph_round(word4_t w, logic [31:0] k0, logic [31:0] k1);
    logic [63:0] pa;
    logic [63:0] pb;
    word4_t      o;
    pa = {32'd0, PH_MUL_A} * {32'd0, w[0]};
    pb = {32'd0, PH_MUL_B} * {32'd0, w[2]};
    o[0] = pb[63:32] ^ w[1] ^ k0;
    o[1] = pb[31:0];
    o[2] = pa[63:32] ^ w[3] ^ k1;
    o[3] = pa[31:0];
    return o;
  endfunction

endpackage

>>> hw/rtl/sphilox_mix.sv
// Five-stage splitmix64 finalizer pipeline with 32-bit partial products.
module sphilox_mix
  import sphilox_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] din,
  output logic [63:0] dout
);

  localparam logic [31:0] A_LO = MIX_MUL_A[31:0];
  localparam logic [31:0] A_HI = MIX_MUL_A[63:32];
  localparam logic [31:0] B_LO = MIX_MUL_B[31:0];
  localparam logic [31:0] B_HI = MIX_MUL_B[63:32];

  logic [63:0] x1, x1_next;
  logic [63:0] pa0, pa0_next;
  logic [31:0] pa1, pa1_next, pa2, pa2_next;
  logic [63:0] x3, x3_next;
  logic [63:0] pb0, pb0_next;
  logic [31:0] pb1, pb1_next, pb2, pb2_next;
  logic [63:0] dout_next;
  logic [63:0] z0, z2, z4;

  // Stage logic: add and shift, products, sum and shift, products, sum and shift
  always_comb begin
    z0       = din + MIX_GAMMA;
    x1_next  = z0 ^ (z0 >> 30);
    pa0_next = {32'd0, x1[31:0]} * {32'd0, A_LO};
    pa1_next = x1[31:0] * A_HI;
    pa2_next = x1[63:32] * A_LO;
    z2       = pa0 + {pa1 + pa2, 32'd0};
    x3_next  = z2 ^ (z2 >> 27);
    pb0_next = {32'd0, x3[31:0]} * {32'd0, B_LO};
    pb1_next = x3[31:0] * B_HI;
    pb2_next = x3[63:32] * B_LO;
    z4       = pb0 + {pb1 + pb2, 32'd0};
    dout_next = z4 ^ (z4 >> 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x1_next;
      pa0  <= pa0_next;
      pa1  <= pa1_next;
      pa2  <= pa2_next;
      x3   <= x3_next;
      pb0  <= pb0_next;
      pb1  <= pb1_next;
      pb2  <= pb2_next;
      dout <= dout_next;
    end
  end

endmodule

>>> hw/rtl/seeded_philox_counter_rng.sv
// Top level: seeded counter-based generator, splitmix64 seed chain and Philox-4x32 rounds.
//
//   channel  handshake            payload
//   in       in_valid / in_stall   member, block_counter
//   out      out_valid / out_stall word_zero..word_three, negate, bad_member
//   cfg      APB write/read        key_high, key_low, epoch, antithetic
//
// One item per cycle while in_stall is low; each item passes the seed mix and then the Philox rounds.
// The key chain (three mix passes on one mix pipeline) runs after reset and after every
// register write; in_stall is high while it runs.
// A stalled result freezes the whole pipeline through one global enable; nothing is dropped.
module seeded_philox_counter_rng
  import sphilox_pkg::*;
#(
  parameter int ROUNDS = DEF_ROUNDS
) (
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [63:0]  member,
  input  logic [63:0]         block_counter,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         word_zero,
  output logic [31:0]         word_one,
  output logic [31:0]         word_two,
  output logic [31:0]         word_three,
  output logic                negate,
  output logic                bad_member,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // ---------------- registers ----------------
  logic [63:0]        key_high;
  logic [63:0]        key_low;
  logic [EPOCH_W-1:0] epoch;
  logic               antithetic;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      epoch      <= '0;
      antithetic <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEY_HIGH:   key_high   <= pwdata;
        REG_KEY_LOW:    key_low    <= pwdata;
        REG_EPOCH:      epoch      <= pwdata[EPOCH_W-1:0];
        REG_ANTITHETIC: antithetic <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KEY_HIGH:   prdata = key_high;
      REG_KEY_LOW:    prdata = key_low;
      REG_EPOCH:      prdata = {1'b0, epoch};
      REG_ANTITHETIC: prdata = {{(DATA_W-1){1'b0}}, antithetic};
    endcase
  end

  // ---------------- key chain sequencer ----------------
  // chain holds the last pass result; once done it is the epoch key.
  ks_state_t         ks_state, ks_state_next;
  logic [KCNT_W-1:0] kcnt, kcnt_next;
  logic [63:0]       chain, chain_next;
  logic [63:0]       kmix_in, kmix_out;
  logic              busy;

  assign busy = (ks_state != KS_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_state <= KS_LOW;
      kcnt     <= '0;
    end else begin
      ks_state <= ks_state_next;
      kcnt     <= kcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    chain <= chain_next;
  end

  always_comb begin
    ks_state_next = ks_state;
    kcnt_next     = kcnt;
    chain_next    = chain;
    kmix_in       = chain;
    unique case (ks_state)
      KS_LOW:   kmix_in = key_low;
      KS_HIGH:  kmix_in = key_high ^ chain;
      KS_EPOCH: kmix_in = chain ^ DOMAIN_EPOCH ^ {1'b0, epoch};
      KS_DONE:  kmix_in = chain;
    endcase
    if (cfg_wr) begin
      ks_state_next = KS_LOW;
      kcnt_next     = '0;
    end else if (busy) begin
      if (kcnt == KCNT_W'(MIX_LAT)) begin
        chain_next = kmix_out;
        kcnt_next  = '0;
        unique case (ks_state)
          KS_LOW:   ks_state_next = KS_HIGH;
          KS_HIGH:  ks_state_next = KS_EPOCH;
          KS_EPOCH: ks_state_next = KS_DONE;
          KS_DONE:  ks_state_next = KS_DONE;
        endcase
      end else begin
        kcnt_next = kcnt + 1'b1;
      end
    end
  end

  sphilox_mix u_key_mix (
    .clk  (clk),
    .en   (1'b1),
    .din  (kmix_in),
    .dout (kmix_out)
  );

  // ---------------- item pipeline control ----------------
  logic               en;
  logic               accept;
  logic [MIX_LAT-1:0] mv;
  logic [ROUNDS-1:0]  pv;

  assign en       = !(pv[ROUNDS-1] && out_stall);
  assign in_stall = rst || busy || !en;
  assign accept   = in_valid && !in_stall;

  // ---------------- seed mix stages ----------------
  logic [63:0] pair;
  logic [63:0] smix_in, seed;
  side_t       side_in;
  side_t       side_q [MIX_LAT];

  always_comb begin
    pair    = antithetic ? {1'b0, member[63:1]} : member;
    smix_in = chain ^ DOMAIN_PAIR ^ pair;
    side_in.counter = block_counter;
    side_in.bad     = member[63];
    side_in.negate  = antithetic && member[0] && !member[63];
  end

  sphilox_mix u_seed_mix (
    .clk  (clk),
    .en   (en),
    .din  (smix_in),
    .dout (seed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (en) begin
      mv <= {mv[MIX_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < MIX_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------- Philox rounds, one stage each ----------------
  ph_t ph_in [ROUNDS];
  ph_t ph_q  [ROUNDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv[0] <= mv[MIX_LAT-1];
      for (int i = 1; i < ROUNDS; i++) begin
        pv[i] <= pv[i-1];
      end
    end
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    logic [31:0] k0, k1;

    if (r == 0) begin : g_first
      always_comb begin
        ph_in[r].w      = {32'd0, 32'd0, side_q[MIX_LAT-1].counter[63:32],
                           side_q[MIX_LAT-1].counter[31:0]};
        ph_in[r].seed   = seed;
        ph_in[r].negate = side_q[MIX_LAT-1].negate;
        ph_in[r].bad    = side_q[MIX_LAT-1].bad;
      end
    end else begin : g_next
      assign ph_in[r] = ph_q[r-1];
    end

    // round key: seed halves plus r bumps
    assign k0 = ph_in[r].seed[31:0]  + bump(r, PH_BUMP_A);
    assign k1 = ph_in[r].seed[63:32] + bump(r, PH_BUMP_B);

    always_ff @(posedge clk) begin
      if (en) begin
        ph_q[r].w      <= ph_round(ph_in[r].w, k0, k1);
        ph_q[r].seed   <= ph_in[r].seed;
        ph_q[r].negate <= ph_in[r].negate;
        ph_q[r].bad    <= ph_in[r].bad;
      end
    end
  end

  // ---------------- result ----------------
  // a negative member yields all-zero words
  assign out_valid  = pv[ROUNDS-1];
  assign word_zero  = ph_q[ROUNDS-1].w[0] & {32{~ph_q[ROUNDS-1].bad}};
  assign word_one   = ph_q[ROUNDS-1].w[1] & {32{~ph_q[ROUNDS-1].bad}};
  assign word_two   = ph_q[ROUNDS-1].w[2] & {32{~ph_q[ROUNDS-1].bad}};
  assign word_three = ph_q[ROUNDS-1].w[3] & {32{~ph_q[ROUNDS-1].bad}};
  assign negate     = ph_q[ROUNDS-1].negate;
  assign bad_member = ph_q[ROUNDS-1].bad;

  // ---------------- checks ----------------
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_member |-> !negate && word_zero == '0 && word_three == '0)
    else $error("bad member result carries data");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    accept |=> mv[0])
    else $error("accepted item lost at pipeline entry");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pv) && $stable(mv))
    else $error("pipeline moved while stalled");

  a_rekey: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> ks_state == KS_LOW && kcnt == '0)
    else $error("key chain not restarted after register write");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept)
    else $error("item accepted while key chain recomputes");

endmodule
